/* design/tti_pkg.sv */
// Shared types and constants for the taint tag tracking unit.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
package tti_pkg;

  localparam int ORIGIN_ENTRIES = 16;
  localparam int SHADOW_BYTES   = 1024;
  localparam int INT_TAG_REGS   = 33;
  localparam int FLOAT_TAG_REGS = 32;
  localparam int OPCODE_SLOTS   = 64;
  localparam int MAX_BYTES      = 8;
  localparam int PC_TAG_INDEX   = 32;

  localparam int OT_IW = (ORIGIN_ENTRIES > 1) ? $clog2(ORIGIN_ENTRIES) : 1;
  localparam int CNT_W = $clog2(ORIGIN_ENTRIES + 1);

  // unified tag store map: memory bytes, int regs, float regs, opcode colors
  localparam int INT_BASE  = SHADOW_BYTES;
  localparam int FLT_BASE  = INT_BASE + INT_TAG_REGS;
  localparam int OPC_BASE  = FLT_BASE + FLOAT_TAG_REGS;
  localparam int TAG_DEPTH = OPC_BASE + OPCODE_SLOTS;
  localparam int TAG_AW    = $clog2(TAG_DEPTH);

  localparam logic [1:0] SP_MEM   = 2'd0;
  localparam logic [1:0] SP_INT   = 2'd1;
  localparam logic [1:0] SP_FLT   = 2'd2;
  localparam logic [1:0] SP_INSTR = 2'd3;

  typedef logic [OT_IW-1:0]  ot_idx_t;
  typedef logic [OT_IW-1:0]  age_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [TAG_AW-1:0] tag_addr_t;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_READ   = 3'd2,
    OP_PROP   = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_OPC    = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BADSPACE = 3'd4,
    ST_RANGE    = 3'd5
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [1:0]  space;
    logic [63:0] addr;
    logic [31:0] pc_or_start;
    logic [31:0] pc_end;
    logic [63:0] color_a;
    logic [63:0] color_b;
    logic [3:0]  byte_count;
    logic [5:0]  instr_index;
    logic        instr_tracked;
  } req_t;

  typedef struct packed {
    logic [63:0] color;
    status_e     status;
  } rsp_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [31:0] pcs;
    logic [31:0] pce;
    logic [1:0]  space;
  } ot_key_t;

  typedef struct packed {
    logic    cmp;
    logic    ins;
    logic    rm;
    ot_idx_t rm_idx;
  } ot_cmd_t;

  typedef struct packed {
    cnt_t free_cnt;
    logic dup;
    logic hit;
    logic scan_match;
    age_t scan_age;
  } ot_stat_t;

  typedef struct packed {
    logic        en;
    logic        we;
    tag_addr_t   addr;
    logic [63:0] wdata;
  } tag_req_t;

endpackage

/* design/tti_origin_table.sv */
// Origin table: entries with PC ranges, registered match vectors, age ranks.
// Depends on tti_pkg.
`timescale 1ns / 1ps
module tti_origin_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tti_pkg::ot_cmd_t  cmd_i,
  input  tti_pkg::ot_key_t  key_i,
  input  logic [63:0]       color_i,
  input  tti_pkg::ot_idx_t  scan_idx_i,
  output tti_pkg::ot_stat_t stat_o,
  output logic [63:0]       hit_color_o
);

  logic [63:0]    o_addr [tti_pkg::ORIGIN_ENTRIES];
  logic [31:0]    o_pcs  [tti_pkg::ORIGIN_ENTRIES];
  logic [31:0]    o_pce  [tti_pkg::ORIGIN_ENTRIES];
  logic [63:0]    o_col  [tti_pkg::ORIGIN_ENTRIES];
  logic [1:0]     o_sp   [tti_pkg::ORIGIN_ENTRIES];
  tti_pkg::age_t  o_age  [tti_pkg::ORIGIN_ENTRIES];
  logic [tti_pkg::ORIGIN_ENTRIES-1:0] valid_q, exact_q, rng_q, exact_d, rng_d;
  tti_pkg::ot_idx_t ins_slot;
  logic [63:0]    hit_col;

  always_comb begin
    ins_slot = '0;
    for (int i = tti_pkg::ORIGIN_ENTRIES - 1; i >= 0; i--) begin
      exact_d[i] = valid_q[i] && o_addr[i] == key_i.addr && o_pcs[i] == key_i.pcs &&
                   o_pce[i] == key_i.pce && o_sp[i] == key_i.space;
      rng_d[i]   = valid_q[i] && o_addr[i] == key_i.addr && o_sp[i] == key_i.space &&
                   o_pcs[i] <= key_i.pcs && o_pce[i] >= key_i.pcs;
      if (!valid_q[i]) begin
        ins_slot = tti_pkg::ot_idx_t'(i);
      end
    end
  end

  always_comb begin
    hit_col = '0;
    for (int i = 0; i < tti_pkg::ORIGIN_ENTRIES; i++) begin
      if (rng_q[i]) begin
        hit_col = hit_col | o_col[i];
      end
    end
  end

  assign hit_color_o         = hit_col;
  assign stat_o.free_cnt     = tti_pkg::cnt_t'($countones(~valid_q));
  assign stat_o.dup          = |exact_q;
  assign stat_o.hit          = |rng_q;
  assign stat_o.scan_match   = exact_q[scan_idx_i];
  assign stat_o.scan_age     = o_age[scan_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.ins) begin
      valid_q[ins_slot] <= 1'b1;
    end else if (cmd_i.rm) begin
      valid_q[cmd_i.rm_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      exact_q <= exact_d;
      rng_q   <= rng_d;
    end
    if (cmd_i.ins) begin
      for (int i = 0; i < tti_pkg::ORIGIN_ENTRIES; i++) begin
        if (valid_q[i]) begin
          o_age[i] <= o_age[i] + 1'b1;
        end
      end
      o_addr[ins_slot] <= key_i.addr;
      o_pcs[ins_slot]  <= key_i.pcs;
      o_pce[ins_slot]  <= key_i.pce;
      o_sp[ins_slot]   <= key_i.space;
      o_col[ins_slot]  <= color_i;
      o_age[ins_slot]  <= '0;
    end else if (cmd_i.rm) begin
      for (int i = 0; i < tti_pkg::ORIGIN_ENTRIES; i++) begin
        if (valid_q[i] && o_age[i] > o_age[cmd_i.rm_idx]) begin
          o_age[i] <= o_age[i] - 1'b1;
        end
      end
    end
  end

endmodule

/* design/tti_tag_store.sv */
// Tag store: one synchronous RAM for memory, register and opcode tags,
// zeroed by a sweep after reset. Depends on tti_pkg.
`timescale 1ns / 1ps
module tti_tag_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tti_pkg::tag_req_t req_i,
  output logic [63:0]       rdata_o,
  output logic              ready_o
);

  logic [63:0]        mem [tti_pkg::TAG_DEPTH];
  logic [63:0]        rdata_q;
  tti_pkg::tag_addr_t clr_q;
  logic               ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      ready_q <= 1'b0;
    end else if (!ready_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == tti_pkg::tag_addr_t'(tti_pkg::TAG_DEPTH - 1)) begin
        ready_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ready_q) begin
      mem[clr_q] <= '0;
    end else if (req_i.en && req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.en) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = ready_q;

endmodule

/* design/taint_tag_tracking_unit.sv */
// One word at a time: clear, opcode read and rejected ops end after dispatch; add and read
// compare, then insert or accumulate, per byte; propagate reads the PC and opcode tags and
// writes the opcode and destination tags; remove scans all 16 origin entries. The next start
// is taken the cycle after the result strobe; results cannot be stalled. After reset the tag
// RAM is zeroed, busy high meanwhile. Depends on tti_pkg, tti_origin_table, tti_tag_store.
`timescale 1ns / 1ps
module taint_tag_tracking_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tti_pkg::req_t req_i,
  output logic          result_valid_o,
  output tti_pkg::rsp_t result_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [63:0]   cfg_data_i
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_DISP  = 13'b0000000000010,
    S_ACMP  = 13'b0000000000100,
    S_AINS  = 13'b0000000001000,
    S_RCMP  = 13'b0000000010000,
    S_RSCAN = 13'b0000000100000,
    S_RDEL  = 13'b0000001000000,
    S_DCMP  = 13'b0000010000000,
    S_DACC  = 13'b0000100000000,
    S_POPC  = 13'b0001000000000,
    S_PWR   = 13'b0010000000000,
    S_PDST  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_e;

  state_e              state_q;
  logic [63:0]         base_q;
  tti_pkg::op_e        op_q;
  logic [1:0]          sp_q;
  logic [63:0]         a_q, ca_q, cb_q, color_q, off;
  logic [31:0]         pc_q, pend_q;
  logic [3:0]          cnt_q, nclamp;
  logic [5:0]          slot_q;
  logic                trk_q, inr, inr_q, slot_ok, found_q, ord_q;
  tti_pkg::status_e    status_q;
  tti_pkg::ot_idx_t    scan_q, best_q;
  tti_pkg::age_t       best_age_q;
  tti_pkg::tag_addr_t  idx, opc_addr;
  tti_pkg::ot_cmd_t    ot_cmd;
  tti_pkg::ot_key_t    ot_key;
  tti_pkg::ot_stat_t   ot_stat;
  tti_pkg::tag_req_t   tag_req;
  logic [63:0]         hit_color, rdata;
  logic                store_ready;

  tti_origin_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ot_cmd),
    .key_i       (ot_key),
    .color_i     (ca_q),
    .scan_idx_i  (scan_q),
    .stat_o      (ot_stat),
    .hit_color_o (hit_color)
  );

  tti_tag_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (tag_req),
    .rdata_o (rdata),
    .ready_o (store_ready)
  );

  assign busy           = (state_q != S_IDLE) || !store_ready;
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = (state_q == S_DONE);
  assign result_o.color  = ord_q ? rdata : color_q;
  assign result_o.status = status_q;

  assign nclamp   = (int'(req_i.byte_count) > tti_pkg::MAX_BYTES) ?
                    4'(tti_pkg::MAX_BYTES) : req_i.byte_count;
  assign slot_ok  = int'(slot_q) < tti_pkg::OPCODE_SLOTS;
  assign off      = a_q - base_q;
  assign opc_addr = tti_pkg::tag_addr_t'(tti_pkg::OPC_BASE) + tti_pkg::tag_addr_t'(slot_q);

  always_comb begin
    case (sp_q)
      tti_pkg::SP_MEM: begin
        inr = off < 64'(tti_pkg::SHADOW_BYTES);
        idx = tti_pkg::tag_addr_t'(off);
      end
      tti_pkg::SP_INT: begin
        inr = a_q < 64'(tti_pkg::INT_TAG_REGS);
        idx = tti_pkg::tag_addr_t'(tti_pkg::INT_BASE) + tti_pkg::tag_addr_t'(a_q);
      end
      tti_pkg::SP_FLT: begin
        inr = a_q < 64'(tti_pkg::FLOAT_TAG_REGS);
        idx = tti_pkg::tag_addr_t'(tti_pkg::FLT_BASE) + tti_pkg::tag_addr_t'(a_q);
      end
      default: begin
        inr = 1'b0;
        idx = '0;
      end
    endcase
  end

  assign ot_key.addr  = a_q;
  assign ot_key.pcs   = pc_q;
  assign ot_key.pce   = pend_q;
  assign ot_key.space = sp_q;
  assign ot_cmd.cmp    = (state_q == S_ACMP) || (state_q == S_RCMP) || (state_q == S_DCMP);
  assign ot_cmd.ins    = (state_q == S_AINS);
  assign ot_cmd.rm     = (state_q == S_RDEL) && found_q;
  assign ot_cmd.rm_idx = best_q;

  always_comb begin
    tag_req = '0;
    case (state_q)
      S_DISP: begin
        case (op_q)
          tti_pkg::OP_PROP: begin
            tag_req.en   = 1'b1;
            tag_req.addr = tti_pkg::tag_addr_t'(tti_pkg::INT_BASE + tti_pkg::PC_TAG_INDEX);
          end
          tti_pkg::OP_OPC: begin
            tag_req.en   = slot_ok;
            tag_req.addr = opc_addr;
          end
          tti_pkg::OP_CLEAR: begin
            tag_req.en   = inr;
            tag_req.we   = 1'b1;
            tag_req.addr = idx;
          end
          default: tag_req = '0;
        endcase
      end
      S_DCMP: begin
        tag_req.en   = inr;
        tag_req.addr = idx;
      end
      S_POPC: begin
        tag_req.en   = slot_ok;
        tag_req.addr = opc_addr;
      end
      S_PWR: begin
        tag_req.en    = trk_q && slot_ok;
        tag_req.we    = 1'b1;
        tag_req.addr  = opc_addr;
        tag_req.wdata = rdata | color_q;
      end
      S_PDST: begin
        tag_req.en    = (sp_q != tti_pkg::SP_INSTR) && inr &&
                        !(sp_q == tti_pkg::SP_INT && a_q == 64'd0);
        tag_req.we    = 1'b1;
        tag_req.addr  = idx;
        tag_req.wdata = color_q;
      end
      default: tag_req = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      state_q <= S_IDLE;
    end else begin
      if (cfg_valid_i) begin
        base_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          if (start && store_ready) begin
            state_q <= S_DISP;
          end
        end
        S_DISP: begin
          case (op_q)
            tti_pkg::OP_PROP: state_q <= S_POPC;
            tti_pkg::OP_OPC:  state_q <= S_DONE;
            default: begin
              if (op_q == tti_pkg::OP_ADD && sp_q != tti_pkg::SP_INSTR &&
                  int'(ot_stat.free_cnt) >= int'(cnt_q) && cnt_q != 4'd0) begin
                state_q <= S_ACMP;
              end else if (op_q == tti_pkg::OP_REMOVE && sp_q != tti_pkg::SP_INSTR) begin
                state_q <= S_RCMP;
              end else if (op_q == tti_pkg::OP_READ && sp_q != tti_pkg::SP_INSTR &&
                           cnt_q != 4'd0) begin
                state_q <= S_DCMP;
              end else begin
                state_q <= S_DONE;
              end
            end
          endcase
        end
        S_ACMP:  state_q <= S_AINS;
        S_AINS:  state_q <= (cnt_q == 4'd1) ? S_DONE : S_ACMP;
        S_RCMP:  state_q <= S_RSCAN;
        S_RSCAN: begin
          if (scan_q == tti_pkg::ot_idx_t'(tti_pkg::ORIGIN_ENTRIES - 1)) begin
            state_q <= S_RDEL;
          end
        end
        S_RDEL:  state_q <= S_DONE;
        S_DCMP:  state_q <= S_DACC;
        S_DACC:  state_q <= (cnt_q == 4'd1) ? S_DONE : S_DCMP;
        S_POPC:  state_q <= S_PWR;
        S_PWR:   state_q <= S_PDST;
        S_PDST:  state_q <= S_DONE;
        S_DONE:  state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q     <= req_i.op;
        sp_q     <= req_i.space;
        a_q      <= req_i.addr;
        pc_q     <= req_i.pc_or_start;
        pend_q   <= req_i.pc_end;
        ca_q     <= req_i.color_a;
        cb_q     <= req_i.color_b;
        cnt_q    <= (req_i.space == tti_pkg::SP_MEM) ? nclamp : 4'd1;
        slot_q   <= req_i.instr_index;
        trk_q    <= req_i.instr_tracked;
        color_q  <= '0;
        status_q <= tti_pkg::ST_OK;
        ord_q    <= 1'b0;
      end
      S_DISP: begin
        case (op_q)
          tti_pkg::OP_PROP: ;
          tti_pkg::OP_OPC: begin
            if (!slot_ok) begin
              status_q <= tti_pkg::ST_RANGE;
            end else begin
              ord_q <= 1'b1;
            end
          end
          default: begin
            if (sp_q == tti_pkg::SP_INSTR && int'(op_q) <= int'(tti_pkg::OP_CLEAR)) begin
              status_q <= tti_pkg::ST_BADSPACE;
            end else if (op_q == tti_pkg::OP_ADD &&
                         int'(ot_stat.free_cnt) < int'(cnt_q)) begin
              status_q <= tti_pkg::ST_FULL;
            end else if (op_q == tti_pkg::OP_CLEAR && !inr) begin
              status_q <= tti_pkg::ST_RANGE;
            end
          end
        endcase
      end
      S_AINS: begin
        if (ot_stat.dup) begin
          status_q <= tti_pkg::ST_DUP;
        end
        a_q   <= a_q + 64'd1;
        cnt_q <= cnt_q - 4'd1;
      end
      S_RCMP: begin
        scan_q  <= '0;
        found_q <= 1'b0;
      end
      S_RSCAN: begin
        if (ot_stat.scan_match && (!found_q || ot_stat.scan_age < best_age_q)) begin
          found_q    <= 1'b1;
          best_q     <= scan_q;
          best_age_q <= ot_stat.scan_age;
        end
        scan_q <= scan_q + 1'b1;
      end
      S_RDEL: begin
        if (!found_q) begin
          status_q <= tti_pkg::ST_NOTFOUND;
        end
      end
      S_DCMP: inr_q <= inr;
      S_DACC: begin
        if (ot_stat.hit) begin
          color_q <= color_q | hit_color;
        end else if (!inr_q) begin
          status_q <= tti_pkg::ST_RANGE;
        end else begin
          color_q <= color_q | rdata;
        end
        a_q   <= a_q + 64'd1;
        cnt_q <= cnt_q - 4'd1;
      end
      S_POPC: color_q <= ca_q | cb_q | rdata;
      S_PDST: begin
        if (sp_q == tti_pkg::SP_INSTR) begin
          status_q <= tti_pkg::ST_BADSPACE;
        end else if (!inr) begin
          status_q <= tti_pkg::ST_RANGE;
        end
      end
      S_DONE: begin
        if (ord_q) begin
          color_q <= color_q;
        end
      end
      default: ;
    endcase
    if (state_q == S_DISP && op_q == tti_pkg::OP_OPC) begin
      color_q <= '0;
    end
    if (state_q == S_DONE && ord_q) begin
      ord_q <= 1'b0;
    end
  end

endmodule

/* tb/taint_tag_tracking_unit_tb.sv */
// Self-checking bench for taint_tag_tracking_unit: directed and random commands,
// a local tag-tracking predictor and a result monitor. Depends on tti_pkg and the RTL.
`timescale 1ns / 1ps
module taint_tag_tracking_unit_tb;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  tti_pkg::req_t req_i = '0;
  logic          result_valid_o;
  tti_pkg::rsp_t result_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [63:0]   cfg_data_i = '0;

  taint_tag_tracking_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .result_valid_o(result_valid_o), .result_o(result_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [63:0] mem_base;
  logic [63:0] o_addr [tti_pkg::ORIGIN_ENTRIES];
  logic [31:0] o_pcs [tti_pkg::ORIGIN_ENTRIES];
  logic [31:0] o_pce [tti_pkg::ORIGIN_ENTRIES];
  logic [63:0] o_col [tti_pkg::ORIGIN_ENTRIES];
  logic [1:0]  o_sp [tti_pkg::ORIGIN_ENTRIES];
  logic        o_vld [tti_pkg::ORIGIN_ENTRIES];
  logic [7:0]  o_age [tti_pkg::ORIGIN_ENTRIES];
  logic [63:0] int_tag [tti_pkg::INT_TAG_REGS];
  logic [63:0] flt_tag [tti_pkg::FLOAT_TAG_REGS];
  logic [63:0] mem_tag [tti_pkg::SHADOW_BYTES];
  logic [63:0] opc_col [tti_pkg::OPCODE_SLOTS];

  tti_pkg::req_t pending_q [$];
  tti_pkg::rsp_t expected_q [$];
  int            errors = 0;
  bit            quiet = 1'b0;
  bit            cfg_pending = 1'b0;
  logic [63:0]   cfg_word;

  function automatic int newest_match(logic [63:0] a, logic [31:0] s, logic [31:0] e,
                                      logic [1:0] sp);
    int best;
    best = -1;
    for (int i = 0; i < tti_pkg::ORIGIN_ENTRIES; i++)
      if (o_vld[i] && o_addr[i] == a && o_pcs[i] == s && o_pce[i] == e && o_sp[i] == sp)
        if (best < 0 || o_age[i] < o_age[best]) best = i;
    return best;
  endfunction

  // returns 1 if in range, with the shadow value in val
  function automatic bit shadow_get(logic [1:0] sp, logic [63:0] a, output logic [63:0] val);
    logic [63:0] off;
    val = '0;
    off = a - mem_base;
    if (sp == tti_pkg::SP_MEM) begin
      if (off < tti_pkg::SHADOW_BYTES) begin val = mem_tag[off[9:0]]; return 1; end
      return 0;
    end
    if (sp == tti_pkg::SP_INT) begin
      if (a < tti_pkg::INT_TAG_REGS) begin val = int_tag[a[5:0]]; return 1; end
      return 0;
    end
    if (a < tti_pkg::FLOAT_TAG_REGS) begin val = flt_tag[a[4:0]]; return 1; end
    return 0;
  endfunction

  function automatic void shadow_put(logic [1:0] sp, logic [63:0] a, logic [63:0] v);
    logic [63:0] off;
    off = a - mem_base;
    if (sp == tti_pkg::SP_MEM) mem_tag[off[9:0]] = v;
    else if (sp == tti_pkg::SP_INT) int_tag[a[5:0]] = v;
    else flt_tag[a[4:0]] = v;
  endfunction

  function automatic tti_pkg::rsp_t predict_tag_op(tti_pkg::req_t r);
    tti_pkg::rsp_t o;
    int            n, need, fr, slot, idx;
    logic [63:0]   a, v, acc;
    bit            hit, inr;
    o.color = '0;
    o.status = tti_pkg::ST_OK;
    n = (r.byte_count > tti_pkg::MAX_BYTES) ? tti_pkg::MAX_BYTES : r.byte_count;
    if (r.op == tti_pkg::OP_PROP) begin
      o.color = r.color_a | r.color_b | int_tag[tti_pkg::PC_TAG_INDEX];
      if (r.instr_tracked) opc_col[r.instr_index] |= o.color;
      if (r.space == tti_pkg::SP_INSTR) o.status = tti_pkg::ST_BADSPACE;
      else begin
        inr = shadow_get(r.space, r.addr, v);
        if (!inr) o.status = tti_pkg::ST_RANGE;
        else if (!(r.space == tti_pkg::SP_INT && r.addr == 0))
          shadow_put(r.space, r.addr, o.color);
      end
    end else if (r.op == tti_pkg::OP_OPC) begin
      o.color = opc_col[r.instr_index];
    end else if (r.op <= tti_pkg::OP_CLEAR && r.space == tti_pkg::SP_INSTR) begin
      o.status = tti_pkg::ST_BADSPACE;
    end else if (r.op == tti_pkg::OP_ADD) begin
      need = (r.space == tti_pkg::SP_MEM) ? n : 1;
      fr = 0;
      for (int i = 0; i < tti_pkg::ORIGIN_ENTRIES; i++) if (!o_vld[i]) fr++;
      if (fr < need) o.status = tti_pkg::ST_FULL;
      else for (int k = 0; k < need; k++) begin
        a = r.addr + k;
        if (newest_match(a, r.pc_or_start, r.pc_end, r.space) >= 0)
          o.status = tti_pkg::ST_DUP;
        slot = -1;
        for (int i = 0; i < tti_pkg::ORIGIN_ENTRIES; i++)
          if (o_vld[i]) o_age[i]++;
          else if (slot < 0) slot = i;
        o_addr[slot] = a; o_pcs[slot] = r.pc_or_start; o_pce[slot] = r.pc_end;
        o_col[slot] = r.color_a; o_sp[slot] = r.space; o_age[slot] = 0;
        o_vld[slot] = 1'b1;
      end
    end else if (r.op == tti_pkg::OP_REMOVE) begin
      idx = newest_match(r.addr, r.pc_or_start, r.pc_end, r.space);
      if (idx < 0) o.status = tti_pkg::ST_NOTFOUND;
      else begin
        o_vld[idx] = 1'b0;
        for (int i = 0; i < tti_pkg::ORIGIN_ENTRIES; i++)
          if (o_vld[i] && o_age[i] > o_age[idx]) o_age[i]--;
      end
    end else if (r.op == tti_pkg::OP_READ) begin
      need = (r.space == tti_pkg::SP_MEM) ? n : 1;
      for (int k = 0; k < need; k++) begin
        a = r.addr + k;
        hit = 0; acc = '0;
        for (int i = 0; i < tti_pkg::ORIGIN_ENTRIES; i++)
          if (o_vld[i] && o_addr[i] == a && o_sp[i] == r.space &&
              o_pcs[i] <= r.pc_or_start && o_pce[i] >= r.pc_or_start) begin
            hit = 1; acc |= o_col[i];
          end
        if (hit) o.color |= acc;
        else if (shadow_get(r.space, a, v)) o.color |= v;
        else o.status = tti_pkg::ST_RANGE;
      end
    end else if (r.op == tti_pkg::OP_CLEAR) begin
      if (shadow_get(r.space, r.addr, v)) shadow_put(r.space, r.addr, '0);
      else o.status = tti_pkg::ST_RANGE;
    end
    return o;
  endfunction

  // driver: random bursts of idle, one command per handshake
  int idle_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) cfg_valid_i <= 1'b0;
      else if (cfg_pending && !cfg_valid_i) begin
        cfg_valid_i <= 1'b1;
        cfg_data_i <= cfg_word;
        cfg_pending <= 1'b0;
      end
      if (start && !busy) begin
        expected_q.push_back(predict_tag_op(req_i));
        if (!quiet && $urandom_range(0, 5) == 0) idle_left = $urandom_range(1, 13);
      end
      if (start && busy) begin
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        start <= 1'b1;
        req_i <= pending_q.pop_front();
      end else start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected word: color %h status %0d", $time, result_o.color,
                 result_o.status);
        errors++;
      end else begin
        tti_pkg::rsp_t e;
        e = expected_q.pop_front();
        if (e.color !== result_o.color) begin
          $display("%0t color mismatch: expected %h actual %h", $time, e.color,
                   result_o.color);
          errors++;
        end
        if (e.status !== result_o.status) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time, e.status,
                   result_o.status);
          errors++;
        end
      end
    end
  end

  int cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic tti_pkg::req_t make_cmd(tti_pkg::op_e op, logic [1:0] sp,
                                             logic [63:0] a, logic [31:0] s,
                                             logic [31:0] e, logic [63:0] ca,
                                             logic [63:0] cb, logic [3:0] n,
                                             logic [5:0] ix, logic tr);
    tti_pkg::req_t r;
    r.op = op; r.space = sp; r.addr = a; r.pc_or_start = s; r.pc_end = e;
    r.color_a = ca; r.color_b = cb; r.byte_count = n; r.instr_index = ix;
    r.instr_tracked = tr;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // bias addresses near the window and the small origin key pool
  function automatic tti_pkg::req_t rand_cmd();
    tti_pkg::req_t r;
    logic [287:0]  raw;
    int            k;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom()};
    r = raw[$bits(tti_pkg::req_t)-1:0];
    k = $urandom_range(0, 9);
    r.op = tti_pkg::op_e'($urandom_range(0, 9) == 0 ? $urandom_range(0, 7) :
                                                      $urandom_range(0, 5));
    r.space = ($urandom_range(0, 9) == 0) ? tti_pkg::SP_INSTR : 2'($urandom_range(0, 2));
    if (k < 8) begin
      if (r.space == tti_pkg::SP_MEM) r.addr = mem_base + $urandom_range(0, 12) - 2;
      else r.addr = $urandom_range(0, 34);
      r.pc_or_start = $urandom_range(0, 3) * 16;
      r.pc_end = r.pc_or_start + $urandom_range(0, 1) * 32;
      if (r.op == tti_pkg::OP_READ) r.pc_or_start = $urandom_range(0, 60);
      r.byte_count = $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 4);
    end else if (k == 8) begin
      r.addr = mem_base + tti_pkg::SHADOW_BYTES - $urandom_range(0, 3);
    end
    return r;
  endfunction

  task automatic drain_and_config(logic [63:0] v);
    while (pending_q.size() > 0 || start || expected_q.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    cfg_word = v;
    cfg_pending = 1'b1;
    @(posedge clk_i);
    while (cfg_pending || cfg_valid_i) @(posedge clk_i);
    mem_base = v;
  endtask

  initial begin
    mem_base = '0;
    for (int i = 0; i < tti_pkg::ORIGIN_ENTRIES; i++) begin
      o_vld[i] = 0; o_addr[i] = 0; o_pcs[i] = 0; o_pce[i] = 0; o_col[i] = 0;
      o_sp[i] = 0; o_age[i] = 0;
    end
    foreach (int_tag[i]) int_tag[i] = '0;
    foreach (flt_tag[i]) flt_tag[i] = '0;
    foreach (mem_tag[i]) mem_tag[i] = '0;
    foreach (opc_col[i]) opc_col[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    pending_q.push_back(make_cmd(tti_pkg::OP_PROP, tti_pkg::SP_INT, 64'd32, 0, 0, 64'h1,
                                 64'h2, 1, 6'd63, 1));
    pending_q.push_back(make_cmd(tti_pkg::OP_PROP, tti_pkg::SP_INT, 64'd0, 0, 0, '1, '1, 1,
                                 6'd0, 1));
    pending_q.push_back(make_cmd(tti_pkg::OP_READ, tti_pkg::SP_INT, 64'd0, 0, 0, 0, 0, 1, 0, 0));
    pending_q.push_back(make_cmd(tti_pkg::OP_ADD, tti_pkg::SP_MEM, 64'd1020, 32'd0, '1, 64'hA5,
                                 0, 4'd8, 0, 0));
    pending_q.push_back(make_cmd(tti_pkg::OP_ADD, tti_pkg::SP_MEM, 64'd1020, 32'd0, '1, 64'h5A,
                                 0, 4'd8, 0, 0));
    pending_q.push_back(make_cmd(tti_pkg::OP_ADD, tti_pkg::SP_MEM, 64'd1020, 32'd0, '1, 64'h5A,
                                 0, 4'd8, 0, 0));
    pending_q.push_back(make_cmd(tti_pkg::OP_READ, tti_pkg::SP_MEM, 64'd1020, '1, 0, 0, 0,
                                 4'd15, 0, 0));
    pending_q.push_back(make_cmd(tti_pkg::OP_READ, tti_pkg::SP_MEM, 64'd1028, 5, 0, 0, 0, 4'd8,
                                 0, 0));
    pending_q.push_back(make_cmd(tti_pkg::OP_REMOVE, tti_pkg::SP_MEM, 64'd1021, 32'd0, '1, 0, 0,
                                 1, 0, 0));
    pending_q.push_back(make_cmd(tti_pkg::OP_REMOVE, tti_pkg::SP_FLT, 64'd3, 0, 0, 0, 0, 1, 0,
                                 0));
    pending_q.push_back(make_cmd(tti_pkg::OP_READ, tti_pkg::SP_MEM, '1, 0, 0, 0, 0, 4'd0, 0, 0));
    pending_q.push_back(make_cmd(tti_pkg::OP_ADD, tti_pkg::SP_MEM, 64'd5, 0, 0, 0, 0, 4'd0, 0,
                                 0));
    pending_q.push_back(make_cmd(tti_pkg::OP_PROP, tti_pkg::SP_FLT, 64'd31, 0, 0, '1, 0, 1,
                                 6'd7, 0));
    pending_q.push_back(make_cmd(tti_pkg::OP_PROP, tti_pkg::SP_FLT, 64'd32, 0, 0, 64'h8, 0, 1,
                                 6'd7, 1));
    pending_q.push_back(make_cmd(tti_pkg::OP_PROP, tti_pkg::SP_INSTR, 64'd1, 0, 0, 64'h10, 0, 1,
                                 6'd7, 1));
    pending_q.push_back(make_cmd(tti_pkg::OP_OPC, tti_pkg::SP_INSTR, 0, 0, 0, 0, 0, 1, 6'd7,
                                 0));
    pending_q.push_back(make_cmd(tti_pkg::OP_CLEAR, tti_pkg::SP_INT, 64'd32, 0, 0, 0, 0, 1, 0,
                                 0));
    pending_q.push_back(make_cmd(tti_pkg::OP_CLEAR, tti_pkg::SP_MEM, 64'd1024, 0, 0, 0, 0, 1, 0,
                                 0));
    pending_q.push_back(make_cmd(tti_pkg::OP_CLEAR, tti_pkg::SP_INSTR, 0, 0, 0, 0, 0, 1, 0, 0));
    pending_q.push_back(make_cmd(tti_pkg::op_e'(3'd6), tti_pkg::SP_MEM, 0, 0, 0, '1, 0, 1, 0,
                                 1));
    pending_q.push_back(make_cmd(tti_pkg::op_e'(3'd7), tti_pkg::SP_INT, 0, 0, 0, 0, 0, 1, 0,
                                 1));
    pending_q.push_back(make_cmd(tti_pkg::OP_READ, tti_pkg::SP_INT, 64'd33, 0, 0, 0, 0, 1, 0,
                                 0));

    // random phases under several window bases
    drain_and_config('1 - 64'd500);
    repeat (250) pending_q.push_back(rand_cmd());
    drain_and_config(64'h0000_0000_0001_0000);
    repeat (250) pending_q.push_back(rand_cmd());
    drain_and_config(64'h8000_0000_0000_0000);
    repeat (250) pending_q.push_back(rand_cmd());
    drain_and_config(64'd0);
    repeat (150) pending_q.push_back(rand_cmd());
    while (pending_q.size() > 0) @(posedge clk_i);
    quiet = 1'b1;
    repeat (150) pending_q.push_back(rand_cmd());

    while (pending_q.size() > 0 || start || expected_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

/* sim.f */
design/tti_pkg.sv
design/tti_origin_table.sv
design/tti_tag_store.sv
design/taint_tag_tracking_unit.sv
tb/taint_tag_tracking_unit_tb.sv
